// ----- sv/two_wire_bus_master_macros.svh -----
// Assertion macros used by the bound assertion checker.
`ifndef TWO_WIRE_BUS_MASTER_MACROS_SVH
`define TWO_WIRE_BUS_MASTER_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is asserted.
`define TWBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TWBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/twbm_pkg.sv -----
`timescale 1ns / 1ps
package twbm_pkg;

  localparam int unsigned ByteBits = 8;
  localparam logic [ByteBits-1:0] ByteMsb = 8'd128;

  localparam logic [4:0] PhaseIdle = 5'd0;
  localparam logic [4:0] PhaseFirst = 5'd1;
  // Write: last bit step, data release, acknowledge clock.
  localparam logic [4:0] PhaseWrBitsEnd = 5'(1 + 3 * ByteBits);
  localparam logic [4:0] PhaseWrRelease = 5'(2 + 3 * ByteBits);
  localparam logic [4:0] PhaseWrAck = 5'(3 + 3 * ByteBits);
  // Read: first step that can close the byte.
  localparam logic [4:0] PhaseRdLast = 5'(2 + 2 * ByteBits);

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_ACK   = 3'd4,
    CMD_NACK  = 3'd5
  } cmd_e;

  // Write bit sub-step: drive data, raise clock, lower clock.
  localparam logic [1:0] SubData = 2'd0;
  localparam logic [1:0] SubHigh = 2'd1;

  typedef struct packed {
    logic [2:0] pad;
    logic       sda_in;
    logic [7:0] tx_byte;
    logic [2:0] mode;
    logic       cmd_valid;
  } in_item_t;

  typedef struct packed {
    logic [2:0] pad;
    logic       ack_error;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } out_item_t;

  typedef struct packed {
    logic [4:0] phase;
    cmd_e       cmd;
    logic [3:0] bit_count;
    logic [7:0] shift;
    logic [7:0] rx;
    logic       scl;
    logic       sda;
    logic       ack_err;
  } step_state_t;

  // (phase - 2) mod 3 for the write bit steps, by folding base-4 digits.
  function automatic logic [1:0] write_sub(input logic [4:0] phase);
    logic [4:0] t;
    logic [2:0] u;
    logic [2:0] v;
    t = phase - 5'd2;
    u = 3'(t[1:0]) + 3'(t[3:2]) + 3'(t[4]);
    v = 3'(u[1:0]) + 3'(u[2]);
    if (v >= 3'd3) begin
      v = v - 3'd3;
    end
    return v[1:0];
  endfunction

endpackage

// ----- sv/two_wire_bus_master.sv -----
`timescale 1ns / 1ps
// Two-wire bus master, bit level. Each item on the slave stream is one bus tick:
// it carries the command offer (cmd_valid, mode, tx_byte) and the sampled data
// line level sda_in. Each tick yields exactly one result item on the master
// stream with the clock and data line levels after the tick's pin step, busy,
// a done pulse, the last received byte and the acknowledge-error flag.
// Commands: start, stop, write byte plus acknowledge sample, read byte, send
// ack, send nack. An offer while busy, or with mode 6 or 7, is ignored.
// A missing acknowledge on a write sets the error flag and ends the command.
// Path: an accepted item waits in the input register, the step logic runs on
// it, and its result is loaded into the result register.
// Throughput: one item per cycle while the result side is not stalled; the step
// logic between the bus state register and the result register is combinational.
// Reset: both lines read released high, the sequencer is idle, the received
// byte and the error flag are zero, and both stream registers are empty.
// Stall: while the result waits on m_axis_tready_i, one more item is held in
// the input register; after that s_axis_tready_o drops until the result is taken.
module two_wire_bus_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cmd_valid[0], mode[3:1], tx_byte[11:4], sda_in[12], zeros[15:13]
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
  // ack_error[12], zeros[15:13]
  output logic [15:0] m_axis_tdata_o
);
  import twbm_pkg::*;

  logic        in_valid;
  logic [15:0] in_data;
  logic        res_ready;
  logic        advance;
  in_item_t    item;
  out_item_t   result;
  step_state_t state_q;
  step_state_t state_d;

  // Input register: holds the accepted tick until the step can run.
  twbm_stage #(
    .Width ($bits(in_item_t))
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (in_valid),
    .ready_i (res_ready),
    .data_o  (in_data)
  );

  assign item = in_item_t'(in_data);

  // Run the step whenever a tick is held and the result register can take its outcome.
  assign advance = in_valid && res_ready;

  twbm_step u_step (
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (result)
  );

  // Bus state: advance once per executed tick only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PhaseIdle;
      state_q.cmd       <= CMD_START;
      state_q.bit_count <= 4'd0;
      state_q.shift     <= 8'd0;
      state_q.rx        <= 8'd0;
      state_q.scl       <= 1'b1;
      state_q.sda       <= 1'b1;
      state_q.ack_err   <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: decouples the master side stall from the step.
  twbm_stage #(
    .Width ($bits(out_item_t))
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (res_ready),
    .data_i  (result),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

endmodule

// ----- sv/twbm_stage.sv -----
`timescale 1ns / 1ps
module twbm_stage #(
  parameter int unsigned Width = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic             valid_d;
  logic [Width-1:0] data_q;
  logic             load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/twbm_step.sv -----
`timescale 1ns / 1ps
module twbm_step (
  input  twbm_pkg::step_state_t state_i,
  input  twbm_pkg::in_item_t    item_i,
  output twbm_pkg::step_state_t state_o,
  output twbm_pkg::out_item_t   result_o
);
  import twbm_pkg::*;

  always_comb begin
    step_state_t st;
    logic        last;
    logic        done;
    st   = state_i;
    last = 1'b0;
    done = 1'b0;

    // Take a new command only while idle and only for a defined mode.
    if (st.phase == PhaseIdle && item_i.cmd_valid && item_i.mode <= CMD_NACK) begin
      st.cmd       = cmd_e'(item_i.mode);
      st.bit_count = 4'd0;
      st.shift     = (item_i.mode == CMD_WRITE) ? item_i.tx_byte : 8'd0;
      st.phase     = PhaseFirst;
    end

    if (st.phase != PhaseIdle) begin
      unique case (st.cmd)
        CMD_START: begin
          if (st.phase == 5'd1) st.sda = 1'b1;
          else if (st.phase == 5'd2) st.scl = 1'b1;
          else begin
            st.sda = 1'b0;
            last   = 1'b1;
          end
        end
        CMD_STOP: begin
          if (st.phase == 5'd1) st.sda = 1'b0;
          else if (st.phase == 5'd2) st.scl = 1'b1;
          else begin
            st.sda = 1'b1;
            last   = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (st.phase == 5'd1) st.scl = 1'b0;
          else if (st.phase <= PhaseWrBitsEnd) begin
            case (write_sub(st.phase))
              SubData: st.sda = |(st.shift & ByteMsb);
              SubHigh: st.scl = 1'b1;
              default: begin
                st.scl       = 1'b0;
                st.shift     = {st.shift[6:0], 1'b0};
                st.bit_count = st.bit_count + 4'd1;
              end
            endcase
          end else if (st.phase == PhaseWrRelease) st.sda = 1'b1;
          else if (st.phase == PhaseWrAck) begin
            st.scl     = 1'b1;
            st.ack_err = item_i.sda_in;
            last       = item_i.sda_in;
          end else begin
            st.scl = 1'b0;
            last   = 1'b1;
          end
        end
        CMD_READ: begin
          if (st.phase == 5'd1) st.scl = 1'b0;
          else if (st.phase == 5'd2) st.sda = 1'b1;
          else if (st.phase[0]) begin
            st.scl   = 1'b1;
            st.shift = {st.shift[6:0], item_i.sda_in};
          end else begin
            st.scl       = 1'b0;
            st.bit_count = st.bit_count + 4'd1;
            if (st.phase >= PhaseRdLast) begin
              st.rx = st.shift;
              last  = 1'b1;
            end
          end
        end
        CMD_ACK: begin
          if (st.phase == 5'd1) st.sda = 1'b0;
          else if (st.phase == 5'd2) st.scl = 1'b1;
          else if (st.phase == 5'd3) st.scl = 1'b0;
          else begin
            st.sda = 1'b1;
            last   = 1'b1;
          end
        end
        default: begin
          if (st.phase == 5'd1) st.sda = 1'b1;
          else if (st.phase == 5'd2) st.scl = 1'b1;
          else begin
            st.scl = 1'b0;
            last   = 1'b1;
          end
        end
      endcase

      if (last) begin
        st.phase = PhaseIdle;
        done     = 1'b1;
      end else begin
        st.phase = st.phase + 5'd1;
      end
    end

    state_o            = st;
    result_o.pad       = 3'd0;
    result_o.ack_error = st.ack_err;
    result_o.rx_byte   = st.rx;
    result_o.done_res  = done;
    result_o.busy_res  = (st.phase != PhaseIdle);
    result_o.sda_out   = st.sda;
    result_o.scl_out   = st.scl;
  end

endmodule

// ----- sv/twbm_checker.sv -----
`timescale 1ns / 1ps
`include "two_wire_bus_master_macros.svh"
module twbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // A stalled result holds.
  `TWBM_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")
  // The finishing tick never reports busy.
  `TWBM_ASSERT(a_done_idle, m_axis_tvalid_o |-> !(m_axis_tdata_o[3] && m_axis_tdata_o[2]), "done and busy together")
  // Input backpressure only comes from a stalled result.
  `TWBM_ASSERT(a_ready_cause, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output stall")
  // No result is offered while reset is held.
  `TWBM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")

endmodule

bind two_wire_bus_master twbm_checker u_twbm_checker (.*);

// ----- tb/sv/twbm_checker.sv -----
`timescale 1ns / 1ps
// Watches both streams of the two-wire bus master, predicts the result item
// for every accepted tick and compares each result item against the oldest prediction.
module twbm_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  output int          errors_o,
  output int          pending_o
);
  import twbm_pkg::*;

  localparam int unsigned WrBitsEnd = 1 + 3 * ByteBits;
  localparam int unsigned WrRelease = 2 + 3 * ByteBits;
  localparam int unsigned WrAck     = 3 + 3 * ByteBits;
  localparam int unsigned RdLast    = 2 + 2 * ByteBits;
  localparam int          ReportMax = 10;

  // Shadow copy of the sequencer.
  logic [4:0] step_q;
  cmd_e       op_q;
  logic [7:0] shift_q;
  logic [7:0] rx_q;
  logic       scl_q;
  logic       sda_q;
  logic       nak_q;

  out_item_t  want_pins_q[$];
  out_item_t  got_pins;
  out_item_t  want_pins;
  in_item_t   tick_in;
  int         mismatch_cnt;

  // Play one tick: take a command if idle, run one pin step, report levels.
  function automatic out_item_t step_bus(input in_item_t it);
    out_item_t   r;
    logic        fin;
    int unsigned s;
    fin = 1'b0;
    if (step_q == 5'd0 && it.cmd_valid && it.mode <= CMD_NACK) begin
      op_q    = cmd_e'(it.mode);
      shift_q = (it.mode == CMD_WRITE) ? it.tx_byte : 8'h00;
      step_q  = 5'd1;
    end
    if (step_q != 5'd0) begin
      s = step_q;
      case (op_q)
        CMD_START: begin
          if (s == 1) sda_q = 1'b1;
          else if (s == 2) scl_q = 1'b1;
          else begin
            sda_q = 1'b0;
            fin   = 1'b1;
          end
        end
        CMD_STOP: begin
          if (s == 1) sda_q = 1'b0;
          else if (s == 2) scl_q = 1'b1;
          else begin
            sda_q = 1'b1;
            fin   = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (s == 1) scl_q = 1'b0;
          else if (s <= WrBitsEnd) begin
            case ((s - 2) % 3)
              0: sda_q = shift_q[7];
              1: scl_q = 1'b1;
              default: begin
                scl_q   = 1'b0;
                shift_q = {shift_q[6:0], 1'b0};
              end
            endcase
          end else if (s == WrRelease) sda_q = 1'b1;
          else if (s == WrAck) begin
            scl_q = 1'b1;
            nak_q = it.sda_in;
            fin   = it.sda_in;
          end else begin
            scl_q = 1'b0;
            fin   = 1'b1;
          end
        end
        CMD_READ: begin
          if (s == 1) scl_q = 1'b0;
          else if (s == 2) sda_q = 1'b1;
          else if (((s - 3) & 1) == 0) begin
            scl_q   = 1'b1;
            shift_q = {shift_q[6:0], it.sda_in};
          end else begin
            scl_q = 1'b0;
            if (s >= RdLast) begin
              rx_q = shift_q;
              fin  = 1'b1;
            end
          end
        end
        CMD_ACK: begin
          if (s == 1) sda_q = 1'b0;
          else if (s == 2) scl_q = 1'b1;
          else if (s == 3) scl_q = 1'b0;
          else begin
            sda_q = 1'b1;
            fin   = 1'b1;
          end
        end
        default: begin
          if (s == 1) sda_q = 1'b1;
          else if (s == 2) scl_q = 1'b1;
          else begin
            scl_q = 1'b0;
            fin   = 1'b1;
          end
        end
      endcase
      step_q = fin ? 5'd0 : step_q + 5'd1;
    end
    r           = '0;
    r.scl_out   = scl_q;
    r.sda_out   = sda_q;
    r.busy_res  = (step_q != 5'd0);
    r.done_res  = fin;
    r.rx_byte   = rx_q;
    r.ack_error = nak_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       = 5'd0;
      op_q         = CMD_START;
      shift_q      = 8'h00;
      rx_q         = 8'h00;
      scl_q        = 1'b1;
      sda_q        = 1'b1;
      nak_q        = 1'b0;
      mismatch_cnt = 0;
      want_pins_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // Check results before queueing this edge's tick.
      if (m_tvalid_i && m_tready_i) begin
        got_pins = out_item_t'(m_tdata_i);
        if (want_pins_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMax)
            $display("%0t twbm_checker: result %h with none expected", $time, m_tdata_i);
        end else begin
          want_pins = want_pins_q.pop_front();
          if (got_pins.scl_out !== want_pins.scl_out ||
              got_pins.sda_out !== want_pins.sda_out ||
              got_pins.busy_res !== want_pins.busy_res ||
              got_pins.done_res !== want_pins.done_res ||
              got_pins.rx_byte !== want_pins.rx_byte ||
              got_pins.ack_error !== want_pins.ack_error ||
              got_pins.pad !== want_pins.pad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ReportMax)
              $display({"%0t twbm_checker: scl/sda/busy/done/rx/aerr/pad",
                        " exp %b %b %b %b %h %b %h got %b %b %b %b %h %b %h"}, $time,
                       want_pins.scl_out, want_pins.sda_out, want_pins.busy_res,
                       want_pins.done_res, want_pins.rx_byte, want_pins.ack_error,
                       want_pins.pad, got_pins.scl_out, got_pins.sda_out,
                       got_pins.busy_res, got_pins.done_res, got_pins.rx_byte,
                       got_pins.ack_error, got_pins.pad);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        tick_in = in_item_t'(s_tdata_i);
        want_pins_q.push_back(step_bus(tick_in));
      end
      errors_o  <= mismatch_cnt;
      pending_o <= want_pins_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Bench top: drives bus ticks into the master, throttles the result stream,
// and reports the verdict from the checker's error count.
module tb_top;
  import twbm_pkg::*;

  // Modes outside the command set; the block must ignore them.
  localparam logic [2:0]  ModeRsvdLo = 3'd6;
  localparam logic [2:0]  ModeRsvdHi = 3'd7;
  localparam int unsigned TickTarget = 1200;
  localparam int unsigned GapPct     = 19;
  localparam int unsigned StallLimit = 4000;
  // Tick, counted from the one that takes a write, that samples the acknowledge.
  localparam int          WrAckTick  = 2 + 3 * ByteBits;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  in_item_t    s_tdata;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  int          errors;
  int          pending;
  int unsigned ticks_sent   = 0;
  int unsigned stall_cycles = 0;
  bit          no_gaps      = 1'b0;

  two_wire_bus_master i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  twbm_tb_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Stall the result side at random, except during the no-gap stretch.
  always @(negedge clk_i) begin
    m_tready <= no_gaps || ($urandom_range(99) >= GapPct);
  end

  // Abort when neither stream moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Bus ticks a command occupies, from the tick that takes it to the one that
  // raises done. A missing acknowledge cuts a write one tick short.
  function automatic int command_ticks(input cmd_e op, input logic nack);
    case (op) inside
      CMD_START, CMD_STOP, CMD_NACK: return 3;
      CMD_WRITE: return nack ? 3 * ByteBits + 3 : 3 * ByteBits + 4;
      CMD_READ:  return 2 * ByteBits + 2;
      default:   return 4;
    endcase
  endfunction

  // Offer one tick; enter and leave at a falling edge, insert random gaps first.
  task automatic offer_tick(input logic v, input logic [2:0] md, input logic [7:0] tx,
                            input logic sd);
    in_item_t it;
    it           = '0;
    it.cmd_valid = v;
    it.mode      = md;
    it.tx_byte   = tx;
    it.sda_in    = sd;
    while (!no_gaps && $urandom_range(99) < GapPct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Issue a command, then fill the ticks it runs for. Busy ticks carry random
  // offers that must be dropped; ticks past the end offer only reserved modes.
  // A negative slack lands the next command on the last busy tick.
  task automatic play_command(input cmd_e op, input logic [7:0] tx, input logic nack,
                              input int slack);
    int         n;
    int         k;
    logic       v;
    logic [2:0] md;
    logic       sd;
    n = command_ticks(op, nack);
    offer_tick(1'b1, op, tx, 1'($urandom_range(1)));
    for (k = 1; k < n + slack; k++) begin
      if (k < n) begin
        v  = ($urandom_range(99) < 25);
        md = 3'($urandom_range(7));
      end else begin
        v  = 1'($urandom_range(1));
        md = $urandom_range(1) ? ModeRsvdLo : ModeRsvdHi;
      end
      // Hold the acknowledge level on the sampling tick of a write.
      sd = (op == CMD_WRITE && k == WrAckTick) ? nack : 1'($urandom_range(1));
      offer_tick(v, md, 8'($urandom), sd);
    end
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    cmd_e        op;
    int unsigned sel;
    int          slack;
    bit          drained_mid;
    drained_mid = 1'b0;
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reserved modes while idle, then every command, with a write
    // of all ones that is acknowledged and one of all zeros that is not.
    offer_tick(1'b1, ModeRsvdLo, 8'h00, 1'b0);
    offer_tick(1'b1, ModeRsvdHi, 8'hFF, 1'b1);
    play_command(CMD_START, 8'h00, 1'b0, 0);
    play_command(CMD_WRITE, 8'hFF, 1'b0, 0);
    play_command(CMD_WRITE, 8'h00, 1'b1, 1);
    play_command(CMD_READ, 8'hFF, 1'b0, 0);
    play_command(CMD_ACK, 8'h5A, 1'b0, 0);
    play_command(CMD_NACK, 8'hA5, 1'b0, 0);
    play_command(CMD_STOP, 8'h00, 1'b0, 1);
    drain_results();

    // Random: mostly back-to-back commands with random content, some stray
    // ticks and some commands that collide with a busy sequencer.
    while (ticks_sent < TickTarget) begin
      no_gaps = (ticks_sent >= 400 && ticks_sent < 650);
      if (!drained_mid && ticks_sent >= 800) begin
        drain_results();
        drained_mid = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 8) begin
        offer_tick(1'($urandom_range(1)), $urandom_range(1) ? ModeRsvdLo : ModeRsvdHi,
                   8'($urandom), 1'($urandom_range(1)));
      end else begin
        op  = cmd_e'(3'($urandom_range(5)));
        sel = $urandom_range(99);
        if (sel < 8) slack = -1;
        else if (sel < 80) slack = 0;
        else slack = int'($urandom_range(3, 1));
        play_command(op, 8'($urandom), 1'($urandom_range(99) < 30), slack);
      end
    end
    no_gaps = 1'b0;

    // Let the pipeline empty and give a stray result a chance to show up.
    drain_results();
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/twbm_pkg.sv
sv/twbm_stage.sv
sv/twbm_step.sv
sv/two_wire_bus_master.sv
sv/twbm_checker.sv
tb/sv/twbm_checker.sv
tb/sv/tb_top.sv
